FILE: src/fmbq_pkg.sv
`timescale 1ns / 1ps

package fmbq_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FAN_IN            = 8;

   localparam int CMD_BITS    = 3;
   localparam int STATUS_BITS = 2;
   localparam int FIELD_BITS  = 32;

   localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_MIDDLE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_POP_FRONT   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_POP_MIDDLE  = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_POP_BACK    = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_REDUCE,
      STATE_RESPOND
   } state_type;

   // per-cell control for one command
   typedef struct packed {
      logic capture;     // a word was accepted: refresh the tap
      logic take_left;   // shift toward the back
      logic take_new;    // load the pushed word
      logic take_right;  // shift toward the front
      logic tap_sel;     // this cell holds the popped word
   } cell_ctl_type;

   // nodes left at a given level of the OR tree
   function automatic int level_width(int n, int l);
      int w;
      w = n;
      for (int k = 0; k < l; k++) begin
         w = (w + FAN_IN - 1) / FAN_IN;
      end
      return w;
   endfunction

   function automatic int tree_levels(int n);
      int lv;
      int w;
      lv = 0;
      w  = n;
      for (int k = 0; k < 16; k++) begin
         if (w > 1) begin
            w  = (w + FAN_IN - 1) / FAN_IN;
            lv = lv + 1;
         end
      end
      if (lv == 0) begin
         lv = 1;
      end
      return lv;
   endfunction

endpackage

FILE: src/fmbq_cell.sv
`timescale 1ns / 1ps

module fmbq_cell #(
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  fmbq_pkg::cell_ctl_type   ctl,
   input  logic [WORD_BITS-1:0]     left_word,
   input  logic [WORD_BITS-1:0]     right_word,
   input  logic [WORD_BITS-1:0]     new_word,
   output logic [WORD_BITS-1:0]     word,
   output logic [WORD_BITS-1:0]     tap
);
   import fmbq_pkg::*;

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [WORD_BITS-1:0] tap_ff, tap_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.take_new) begin
         word_in = new_word;
      end else if (ctl.take_left) begin
         word_in = left_word;
      end else if (ctl.take_right) begin
         word_in = right_word;
      end
   end

   // tap holds the old word of the popped cell, zero elsewhere
   always_comb begin
      tap_in = tap_ff;
      if (ctl.capture) begin
         tap_in = ctl.tap_sel ? word_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tap_ff  <= tap_in;
   end

   assign word = word_ff;
   assign tap  = tap_ff;

endmodule

FILE: src/fmbq_or_tree.sv
`timescale 1ns / 1ps

module fmbq_or_tree #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic [WORD_BITS-1:0] leaf [DEPTH],
   output logic [WORD_BITS-1:0] root
);
   import fmbq_pkg::*;

   localparam int LEVELS = tree_levels(DEPTH);

   // level l of the tree sits at row l-1
   logic [WORD_BITS-1:0] node_ff [LEVELS][DEPTH];

   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      for (genvar j = 0; j < DEPTH; j++) begin : g_node
         if (j < level_width(DEPTH, l)) begin : g_used
            logic [WORD_BITS-1:0] kids [FAN_IN];
            logic [WORD_BITS-1:0] node_in;
            for (genvar k = 0; k < FAN_IN; k++) begin : g_kid
               if (j * FAN_IN + k < level_width(DEPTH, l - 1)) begin : g_live
                  if (l == 1) begin : g_leaf
                     assign kids[k] = leaf[j * FAN_IN + k];
                  end else begin : g_inner
                     assign kids[k] = node_ff[l-2][j * FAN_IN + k];
                  end
               end else begin : g_pad
                  assign kids[k] = '0;
               end
            end
            always_comb begin
               node_in = '0;
               for (int k = 0; k < FAN_IN; k++) begin
                  node_in = node_in | kids[k];
               end
            end
            always_ff @(posedge clock) begin
               node_ff[l-1][j] <= node_in;
            end
         end else begin : g_unused
            always_ff @(posedge clock) begin
               node_ff[l-1][j] <= '0;
            end
         end
      end
   end

   assign root = node_ff[LEVELS-1][0];

endmodule

FILE: src/front_middle_back_queue_core.sv
`timescale 1ns / 1ps
// Front/middle/back queue held in a row of cells, front word in cell 0.
// The response waits for the tap words to climb the OR tree, whose depth is
//   LEVELS = ceil(log8(DEPTH)) (2 for DEPTH = 64).
// A new word is taken only while idle or as the waiting response is taken.
// Reset: synchronous, active high; clears the item count and the control.
module front_middle_back_queue_core #(
   parameter int DEPTH     = fmbq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = fmbq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fmbq_pkg::CMD_BITS-1:0]         req_command,
   input  logic signed [fmbq_pkg::FIELD_BITS-1:0] req_push_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fmbq_pkg::FIELD_BITS-1:0] rsp_pop_value,
   output logic [fmbq_pkg::STATUS_BITS-1:0]      rsp_status
);
   import fmbq_pkg::*;

   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int LEVELS     = tree_levels(DEPTH);
   localparam int LVL_BITS   = $clog2(LEVELS + 1);

   // ------------------------------------------------------------------
   // Handshake and sequencing
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [LVL_BITS-1:0] lvl_ff, lvl_in;
   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_take) begin
               state_in = STATE_REDUCE;
               lvl_in   = LVL_BITS'(LEVELS - 1);
            end
         end
         STATE_REDUCE: begin
            // count down the OR tree stages
            if (lvl_ff == '0) begin
               state_in = STATE_RESPOND;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         STATE_RESPOND: begin
            if (rsp_take && req_take) begin
               state_in = STATE_REDUCE;
               lvl_in   = LVL_BITS'(LEVELS - 1);
            end else if (rsp_take) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // A new word may enter in the same cycle the waiting response leaves.
   always_comb begin
      rsp_valid = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         STATE_IDLE: begin
            req_stall = 1'b0;
         end
         STATE_REDUCE: begin
            req_stall = 1'b1;
         end
         STATE_RESPOND: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   // ------------------------------------------------------------------
   // Command decode and position
   // ------------------------------------------------------------------
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] count_m1;
   logic [COUNT_BITS-1:0] pos_wide;
   logic [IDX_BITS-1:0]   pos;
   logic is_push, is_pop, full, empty;
   logic push_ok, pop_ok;

   assign is_push  = req_command inside {CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK};
   assign is_pop   = req_command inside {CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK};
   assign full     = (count_ff == COUNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = req_take && is_push && !full;
   assign pop_ok   = req_take && is_pop && !empty;
   assign count_m1 = count_ff - 1'b1;

   // middle push lands at floor(n/2), middle pop at floor((n-1)/2)
   always_comb begin
      case (req_command)
         CMD_PUSH_FRONT:  pos_wide = '0;
         CMD_PUSH_MIDDLE: pos_wide = count_ff >> 1;
         CMD_PUSH_BACK:   pos_wide = count_ff;
         CMD_POP_FRONT:   pos_wide = '0;
         CMD_POP_MIDDLE:  pos_wide = count_m1 >> 1;
         CMD_POP_BACK:    pos_wide = count_m1;
         default:         pos_wide = '0;
      endcase
   end

   // a full store never pushes, so the back position always fits
   assign pos = pos_wide[IDX_BITS-1:0];

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Cell row: every cell compares its index with the position and either
   // holds, takes its neighbor's word, or takes the pushed word.
   // ------------------------------------------------------------------
   logic [FIELD_BITS+WORD_BITS-1:0] push_ext;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] cell_word [DEPTH];
   logic [WORD_BITS-1:0] cell_tap  [DEPTH];

   // cut or sign-extend the pushed field to the stored width
   assign push_ext = {{WORD_BITS{req_push_value[FIELD_BITS-1]}}, req_push_value};
   assign new_word = push_ext[WORD_BITS-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [IDX_BITS-1:0] CELL_IDX = IDX_BITS'(i);
      cell_ctl_type ctl;
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_front
         assign left_word = new_word;
      end else begin : g_mid_left
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_back
         assign right_word = cell_word[i];
      end else begin : g_mid_right
         assign right_word = cell_word[i+1];
      end

      assign ctl.capture    = req_take;
      assign ctl.take_new   = push_ok && (CELL_IDX == pos);
      assign ctl.take_left  = push_ok && (CELL_IDX > pos);
      assign ctl.take_right = pop_ok && (CELL_IDX >= pos);
      assign ctl.tap_sel    = pop_ok && (CELL_IDX == pos);

      fmbq_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_word  (left_word),
         .right_word (right_word),
         .new_word   (new_word),
         .word       (cell_word[i]),
         .tap        (cell_tap[i])
      );
   end

   // Only the popped cell drives a nonzero tap, so an OR gathers it.
   logic [WORD_BITS-1:0] root;

   fmbq_or_tree #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_or_tree (
      .clock (clock),
      .leaf  (cell_tap),
      .root  (root)
   );

   // ------------------------------------------------------------------
   // Response word
   // ------------------------------------------------------------------
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic popped_ff, popped_in;
   logic [FIELD_BITS+WORD_BITS-1:0] root_ext;

   always_comb begin
      status_in = status_ff;
      popped_in = popped_ff;
      if (req_take) begin
         popped_in = pop_ok;
         status_in = STATUS_DONE;
         if (is_push && full) begin
            status_in = STATUS_FULL;
         end else if (is_pop && empty) begin
            status_in = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign root_ext = {{FIELD_BITS{root[WORD_BITS-1]}}, root};

   always_comb begin
      if (popped_ff) begin
         rsp_pop_value = root_ext[FIELD_BITS-1:0];
      end else if (status_ff == STATUS_EMPTY) begin
         rsp_pop_value = '1;
      end else begin
         rsp_pop_value = '0;
      end
   end

   assign rsp_status = status_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import fmbq_pkg::*;

   localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
   localparam int WORD_BITS      = WORD_BITS_DEFAULT;
   localparam int SETTLE_CYCLES  = 8;     // allow slack after the last reply
   localparam int TIMEOUT_CYCLES = 1000;  // cycles with no handshake on either side

   // command codes the block decodes as no-ops
   localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [FIELD_BITS-1:0] pop_value;
      logic [STATUS_BITS-1:0]       status;
   } reply_type;

   // Shadow copy of the queue plus the replies it owes, oldest first.
   class queue_scoreboard;
      logic signed [WORD_BITS-1:0] words[$];
      reply_type                   owed[$];
      int                          errors;
      int                          cmd_seen[8];
      int                          full_drops;
      int                          empty_pops;
      int                          replies_checked;
      int                          peak_fill;

      function void note_command(logic [CMD_BITS-1:0] cmd,
                                 logic signed [FIELD_BITS-1:0] value);
         reply_type                   want;
         int                          pos;
         logic signed [WORD_BITS-1:0] taken;
         want.pop_value = '0;
         want.status    = STATUS_DONE;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
               if (words.size() >= QUEUE_DEPTH) begin
                  want.status = STATUS_FULL;
                  full_drops++;
               end else begin
                  if (cmd == CMD_PUSH_FRONT) pos = 0;
                  else if (cmd == CMD_PUSH_MIDDLE) pos = words.size() / 2;
                  else pos = words.size();
                  words.insert(pos, WORD_BITS'(value));
                  if (words.size() > peak_fill) peak_fill = words.size();
               end
            end
            CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
               if (words.size() == 0) begin
                  want.pop_value = '1;
                  want.status    = STATUS_EMPTY;
                  empty_pops++;
               end else begin
                  if (cmd == CMD_POP_FRONT) pos = 0;
                  else if (cmd == CMD_POP_MIDDLE) pos = (words.size() - 1) / 2;
                  else pos = words.size() - 1;
                  taken = words[pos];
                  words.delete(pos);
                  want.pop_value = FIELD_BITS'(taken);
               end
            end
            default: ;
         endcase
         owed.insert(owed.size(), want);
      endfunction

      function void check_response(logic signed [FIELD_BITS-1:0] pop_value,
                                   logic [STATUS_BITS-1:0] status);
         reply_type want;
         if (owed.size() == 0) begin
            $error("response with nothing owed: pop_value %0d status %0d",
                   pop_value, status);
            errors++;
         end else begin
            want = owed[0];
            owed.delete(0);
            replies_checked++;
            if (pop_value !== want.pop_value) begin
               $error("pop_value: expected %0d, got %0d", want.pop_value, pop_value);
               errors++;
            end
            if (status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, status);
               errors++;
            end
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [CMD_BITS-1:0]           req_command;
   logic signed [FIELD_BITS-1:0]  req_push_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [FIELD_BITS-1:0]  rsp_pop_value;
   logic [STATUS_BITS-1:0]        rsp_status;

   wire in_fire  = req_valid && !req_stall;
   wire out_fire = rsp_valid && !rsp_stall;

   queue_scoreboard sb;
   int              idle_pct;    // chance the sender inserts a gap before a word
   int              stall_pct;   // chance the receiver starts a stall burst
   int              quiet_cycles;

   logic [CMD_BITS-1:0] push_kinds[3] = '{CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK};
   logic [CMD_BITS-1:0] pop_kinds[3]  = '{CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK};

   front_middle_back_queue_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sample both channels at the rising edge, before any register updates land.
   // Check the response first: a reply at this edge can only belong to a word
   // accepted at an earlier edge, so noting the new word afterwards is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (out_fire) sb.check_response(rsp_pop_value, rsp_status);
         if (in_fire) sb.note_command(req_command, req_push_value);
      end
   end

   // Stall the response side in bursts; stall_pct of zero
   // keeps rsp_stall low for a whole stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < TIMEOUT_CYCLES) begin
         @(posedge clock);
         if (reset || in_fire || out_fire) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("front_middle_back_queue_core regression: fail");
      $finish;
   end

   // Favor the corner values, otherwise any 32-bit pattern.
   function automatic logic signed [FIELD_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly pushes or pops by push_pct, with a trickle of no-op codes.
   function automatic logic [CMD_BITS-1:0] pick_command(int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      if (roll < 3 + push_pct) return push_kinds[$urandom_range(0, 2)];
      return pop_kinds[$urandom_range(0, 2)];
   endfunction

   // Drive one word: maybe idle first, then hold it until it is taken.
   // Enter and leave at a falling edge.
   task automatic send_word(logic [CMD_BITS-1:0] cmd, logic signed [FIELD_BITS-1:0] value);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off the sender until every owed reply has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic send_mixed(int count, int push_pct);
      repeat (count) send_word(pick_command(push_pct), pick_value());
   endtask

   // Push well past full, then pop well past empty, with random positions.
   task automatic fill_and_empty();
      repeat (QUEUE_DEPTH + 6) send_word(push_kinds[$urandom_range(0, 2)], pick_value());
      repeat (QUEUE_DEPTH + 5) send_word(pop_kinds[$urandom_range(0, 2)], pick_value());
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_PUSH_FRONT;
      req_push_value = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: pops on an empty store, the no-op codes, corner values
      // through every push position, then pops from each position to empty.
      send_word(CMD_POP_FRONT, 32'sd5);
      send_word(CMD_POP_MIDDLE, '0);
      send_word(CMD_POP_BACK, '1);
      send_word(CMD_SPARE_6, 32'sh7fff_ffff);
      send_word(CMD_SPARE_7, 32'sh8000_0000);
      send_word(CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_word(CMD_PUSH_BACK, 32'sh8000_0000);
      send_word(CMD_PUSH_MIDDLE, '0);
      send_word(CMD_PUSH_MIDDLE, '1);
      send_word(CMD_PUSH_FRONT, 32'sd1);
      send_word(CMD_PUSH_MIDDLE, 32'sh5555_aaaa);
      send_word(CMD_POP_MIDDLE, '0);
      send_word(CMD_POP_MIDDLE, '0);
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_POP_BACK, '0);
      send_word(CMD_POP_MIDDLE, '0);
      send_word(CMD_POP_FRONT, '0);
      send_word(CMD_POP_MIDDLE, '0);
      send_word(CMD_SPARE_6, '0);

      // Random mix with gaps and stalls on both sides.
      idle_pct  = 25;
      stall_pct = 25;
      send_mixed(450, 55);
      drain_replies();

      // Full and empty sweeps under different backpressure.
      idle_pct  = 40;
      stall_pct = 40;
      fill_and_empty();
      idle_pct  = 0;
      stall_pct = 0;
      fill_and_empty();
      idle_pct  = 15;
      stall_pct = 30;
      fill_and_empty();
      drain_replies();

      idle_pct  = 30;
      stall_pct = 20;
      send_mixed(200, 45);

      // Tail: back to back, no idling on either side.
      idle_pct  = 0;
      stall_pct = 0;
      send_mixed(250, 50);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d replies: push f/m/b %0d/%0d/%0d, pop f/m/b %0d/%0d/%0d, no-op %0d",
               sb.replies_checked, sb.cmd_seen[CMD_PUSH_FRONT], sb.cmd_seen[CMD_PUSH_MIDDLE],
               sb.cmd_seen[CMD_PUSH_BACK], sb.cmd_seen[CMD_POP_FRONT],
               sb.cmd_seen[CMD_POP_MIDDLE], sb.cmd_seen[CMD_POP_BACK],
               sb.cmd_seen[CMD_SPARE_6] + sb.cmd_seen[CMD_SPARE_7]);
      $display("dropped pushes on full %0d, pops on empty %0d, peak fill %0d of %0d",
               sb.full_drops, sb.empty_pops, sb.peak_fill, QUEUE_DEPTH);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("front_middle_back_queue_core regression: pass");
      end else begin
         $display("front_middle_back_queue_core regression: fail");
      end
      $finish;
   end

endmodule
